### sv/aab_pkg.sv
// ============================================================================
// Alpha blend blit package
// Shared types, register codes and the blend rounding helper.
// ============================================================================
package aab_pkg;

   // Width of the configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Bytes per pixel and the matching offset shift.
   localparam int PIXEL_BYTES = 4;
   localparam int PIXEL_SHIFT = $clog2(PIXEL_BYTES);

   // Depth of the queue between the front and the back end.
   localparam int QUEUE_DEPTH = 4;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_DEST_X       = 3'd0,
      REG_DEST_Y       = 3'd1,
      REG_IMAGE_WIDTH  = 3'd2,
      REG_IMAGE_HEIGHT = 3'd3,
      REG_DEST_PITCH   = 3'd4,
      REG_SRC_PITCH    = 3'd5
   } reg_index_type;

   // Configuration as seen by the datapath, with sizes already clamped.
   typedef struct packed {
      logic [11:0] dest_x;
      logic [11:0] dest_y;
      logic [12:0] width;
      logic [12:0] height;
      logic [15:0] dest_pitch;
      logic [15:0] src_pitch;
   } cfg_type;

   // Divides a blend sum by 255, rounding half up.
   // The first estimate is never high and at most one low, so a single
   // compare and increment makes it exact.
   function automatic logic [7:0] blend_round(input logic [15:0] x);
      logic [16:0] y;
      logic [16:0] q0;
      logic [16:0] rem;
      y   = 17'(x) + 17'd127;
      q0  = (y + (y >> 8)) >> 8;
      rem = y - ((q0 << 8) - q0);
      if (rem >= 17'd255) begin
         q0 = q0 + 17'd1;
      end
      return q0[7:0];
   endfunction

endpackage

### sv/aab_if.sv
// ============================================================================
// Alpha blend blit channel interfaces
// Valid/ready channels for pixel requests, blended responses and
// configuration writes.
// ============================================================================

// Pixel pair request channel.
interface aab_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] src_pixel;
   logic [31:0] dst_pixel;

   modport source (output valid, output src_pixel, output dst_pixel, input ready);
   modport sink   (input valid, input src_pixel, input dst_pixel, output ready);
endinterface

// Blended pixel response channel.
interface aab_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] out_pixel;
   logic [31:0] dst_offset;
   logic [31:0] src_offset;
   logic        last_pixel;

   modport source (output valid, output out_pixel, output dst_offset,
                   output src_offset, output last_pixel, input ready);
   modport sink   (input valid, input out_pixel, input dst_offset,
                   input src_offset, input last_pixel, output ready);
endinterface

// Configuration write channel.
interface aab_csr_if;
   import aab_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/aab_front.sv
// ============================================================================
// Alpha blend blit front end
// Accepts pixel pairs, tracks the raster position and tags each
// transaction with its column, row and end-of-blit flag.
// ============================================================================
module aab_front #(
   parameter int CNT_W   = 12,
   parameter int ENTRY_W = 64 + 2 * CNT_W + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  aab_pkg::cfg_type     cfg,
   aab_req_if.sink              req_ch,
   output logic                 push_valid,
   input  logic                 push_ready,
   output logic [ENTRY_W-1:0]   push_data
);
   import aab_pkg::*;

   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic             row_end;
   logic             col_last;
   logic             accept;

   // The queue takes the transaction directly.
   assign req_ch.ready = push_ready;
   assign push_valid   = req_ch.valid;
   assign accept       = req_ch.valid && push_ready;

   // A line is complete once the next position reaches the size; a counter
   // left beyond a shrunk size also completes its line.
   assign row_end  = (32'(col_ff) + 32'd1) >= 32'(cfg.width);
   assign col_last = (32'(row_ff) + 32'd1) >= 32'(cfg.height);

   assign push_data = {req_ch.src_pixel, req_ch.dst_pixel, col_ff, row_ff,
                       row_end && col_last};

   // Raster position for the next transaction.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            if (col_last) begin
               row_in = '0;
            end else begin
               row_in = row_ff + CNT_W'(1);
            end
         end else begin
            col_in = col_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

### sv/aab_queue.sv
// ============================================================================
// Alpha blend blit queue
// Small first-in first-out buffer that decouples the front end from the
// blend and address back end.
// ============================================================================
module aab_queue #(
   parameter int WIDTH = 89,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage holds payload only.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/aab_back.sv
// ============================================================================
// Alpha blend blit back end
// Two-stage pipeline: the first stage forms the channel products and the
// offset products, the second rounds, sums and holds the response.
// ============================================================================
module aab_back #(
   parameter int CNT_W   = 12,
   parameter int ENTRY_W = 64 + 2 * CNT_W + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  aab_pkg::cfg_type     cfg,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  logic [ENTRY_W-1:0]   pop_data,
   aab_rsp_if.source            rsp_ch
);
   import aab_pkg::*;

   // Width of the destination position sums and of the signed source row.
   localparam int SUM_W  = ((CNT_W > 12) ? CNT_W : 12) + 1;
   localparam int DIFF_W = ((CNT_W > 13) ? CNT_W : 13) + 2;

   logic [31:0]      src_pix;
   logic [31:0]      dst_pix;
   logic [CNT_W-1:0] col;
   logic [CNT_W-1:0] row;
   logic             last;

   logic [7:0]              alpha;
   logic [15:0]             mix_in [3];
   logic [SUM_W-1:0]        dy_sum;
   logic [SUM_W-1:0]        dx_sum;
   logic [SUM_W+15:0]       d_prod;
   logic [DIFF_W-1:0]       s_diff;
   logic signed [DIFF_W+16:0] s_prod;

   logic        s1_valid_ff, s1_valid_in;
   logic [15:0] mix_ff [3];
   logic [31:0] drow_ff, drow_in;
   logic [31:0] dcol_ff, dcol_in;
   logic [31:0] srow_ff, srow_in;
   logic [31:0] scol_ff, scol_in;
   logic        s1_last_ff;

   logic        s2_valid_ff, s2_valid_in;
   logic [23:0] pixel_ff, pixel_in;
   logic [31:0] doff_ff, doff_in;
   logic [31:0] soff_ff, soff_in;
   logic        s2_last_ff;

   logic        s1_ready;
   logic        s2_ready;

   // Unpack the queued transaction.
   assign src_pix = pop_data[ENTRY_W-1 -: 32];
   assign dst_pix = pop_data[ENTRY_W-33 -: 32];
   assign col     = pop_data[2*CNT_W : CNT_W+1];
   assign row     = pop_data[CNT_W:1];
   assign last    = pop_data[0];

   // Stall control: a stage moves when the stage after it has room.
   assign s2_ready  = !s2_valid_ff || rsp_ch.ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign pop_ready = s1_ready;

   // Stage one: per-channel weighted sum and the offset products.
   assign alpha = src_pix[31:24];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         mix_in[c] = 16'(8'hFF - alpha) * 16'(dst_pix[8*c +: 8])
                   + 16'(alpha) * 16'(src_pix[8*c +: 8]);
      end
   end

   assign dy_sum  = SUM_W'(cfg.dest_y) + SUM_W'(row);
   assign dx_sum  = SUM_W'(cfg.dest_x) + SUM_W'(col);
   assign d_prod  = (SUM_W+16)'(dy_sum) * (SUM_W+16)'(cfg.dest_pitch);
   assign drow_in = 32'(d_prod);
   assign dcol_in = 32'(dx_sum) << PIXEL_SHIFT;

   // The source row term may go negative after a size change; it wraps.
   assign s_diff  = DIFF_W'(cfg.height) - DIFF_W'(row) - DIFF_W'(1);
   assign s_prod  = $signed(s_diff) * $signed({1'b0, cfg.src_pitch});
   assign srow_in = 32'(s_prod);
   assign scol_in = 32'(col) << PIXEL_SHIFT;

   assign s1_valid_in = s1_ready ? pop_valid : s1_valid_ff;

   // Stage two: rounding and offset sums.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         pixel_in[8*c +: 8] = blend_round(mix_ff[c]);
      end
   end

   assign doff_in     = drow_ff + dcol_ff;
   assign soff_in     = srow_ff + scol_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         mix_ff     <= mix_in;
         drow_ff    <= drow_in;
         dcol_ff    <= dcol_in;
         srow_ff    <= srow_in;
         scol_ff    <= scol_in;
         s1_last_ff <= last;
      end
      if (s2_ready) begin
         pixel_ff   <= pixel_in;
         doff_ff    <= doff_in;
         soff_ff    <= soff_in;
         s2_last_ff <= s1_last_ff;
      end
   end

   assign rsp_ch.valid      = s2_valid_ff;
   assign rsp_ch.out_pixel  = pixel_ff;
   assign rsp_ch.dst_offset = doff_ff;
   assign rsp_ch.src_offset = soff_ff;
   assign rsp_ch.last_pixel = s2_last_ff;

endmodule

### sv/alpha_blend_blit_unit.sv
// ============================================================================
// Alpha blend blit unit
// Blends ARGB source pixels over destination pixels and reports the byte
// offsets of each pixel in both images.
// ============================================================================
// A request transaction taken at an edge is written into the queue, then passes
// the two pipeline stages before response valid.
// Throughput: one pixel per clock, paced by the two-stage blend and
// address pipeline behind the queue; it stalls only when responses back up.
// Reset: synchronous; clears the raster counters, the queue and the
// pipeline, and loads the configuration reset values.
module alpha_blend_blit_unit #(
   parameter int MAX_DIM = 4096
) (
   input  logic      clock,
   input  logic      reset,
   aab_req_if.sink   req_ch,
   aab_rsp_if.source rsp_ch,
   aab_csr_if.sink   csr_ch
);
   import aab_pkg::*;

   localparam int CNT_W   = $clog2(MAX_DIM);
   localparam int ENTRY_W = 64 + 2 * CNT_W + 1;
   // Largest size a 13-bit register can reach after clamping.
   localparam int DIM_CAP = (MAX_DIM > 8191) ? 8191 : MAX_DIM;

   logic [11:0] dest_x_ff, dest_x_in;
   logic [11:0] dest_y_ff, dest_y_in;
   logic [12:0] width_ff, width_in;
   logic [12:0] height_ff, height_in;
   logic [15:0] dest_pitch_ff, dest_pitch_in;
   logic [15:0] src_pitch_ff, src_pitch_in;

   cfg_type            cfg;
   logic               push_valid;
   logic               push_ready;
   logic [ENTRY_W-1:0] push_data;
   logic               pop_valid;
   logic               pop_ready;
   logic [ENTRY_W-1:0] pop_data;

   // Sizes of zero count as one; sizes above the limit count as the limit.
   function automatic logic [12:0] clamp_dim(input logic [12:0] v);
      logic [12:0] r;
      r = v;
      if (v == '0) begin
         r = 13'd1;
      end else if (32'(v) > DIM_CAP) begin
         r = 13'(DIM_CAP);
      end
      return r;
   endfunction

   // Configuration writes are always taken; unknown indexes are dropped.
   assign csr_ch.ready = 1'b1;

   always_comb begin
      dest_x_in     = dest_x_ff;
      dest_y_in     = dest_y_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      dest_pitch_in = dest_pitch_ff;
      src_pitch_in  = src_pitch_ff;
      if (csr_ch.valid) begin
         case (reg_index_type'(csr_ch.index))
            REG_DEST_X:       dest_x_in     = csr_ch.data[11:0];
            REG_DEST_Y:       dest_y_in     = csr_ch.data[11:0];
            REG_IMAGE_WIDTH:  width_in      = csr_ch.data[12:0];
            REG_IMAGE_HEIGHT: height_in     = csr_ch.data[12:0];
            REG_DEST_PITCH:   dest_pitch_in = csr_ch.data;
            REG_SRC_PITCH:    src_pitch_in  = csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_x_ff     <= 12'd0;
         dest_y_ff     <= 12'd0;
         width_ff      <= 13'd1;
         height_ff     <= 13'd1;
         dest_pitch_ff <= 16'd4;
         src_pitch_ff  <= 16'd4;
      end else begin
         dest_x_ff     <= dest_x_in;
         dest_y_ff     <= dest_y_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         dest_pitch_ff <= dest_pitch_in;
         src_pitch_ff  <= src_pitch_in;
      end
   end

   // Effective configuration for both halves of the datapath.
   always_comb begin
      cfg.dest_x     = dest_x_ff;
      cfg.dest_y     = dest_y_ff;
      cfg.width      = clamp_dim(width_ff);
      cfg.height     = clamp_dim(height_ff);
      cfg.dest_pitch = dest_pitch_ff;
      cfg.src_pitch  = src_pitch_ff;
   end

   aab_front #(
      .CNT_W   (CNT_W),
      .ENTRY_W (ENTRY_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   aab_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   aab_back #(
      .CNT_W   (CNT_W),
      .ENTRY_W (ENTRY_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_ch    (rsp_ch)
   );

endmodule

### verif/tb_alpha_blend_blit_unit.sv
// ============================================================================
// Alpha blend blit unit testbench
// Drives pixel pairs and register writes into the blit unit. A model of the
// blend arithmetic and the raster walk predicts each response, and every
// response transaction is compared with the oldest prediction, field by
// field. Directed tests cover the defaults, the register extremes and a
// resize in the middle of a blit. Random traffic then runs under four
// idle and back-pressure profiles.
// ============================================================================
module tb_alpha_blend_blit_unit;
   import aab_pkg::*;

   localparam int BLIT_MAX_DIM = 4096;
   localparam int RUN_LIMIT    = 4_000_000;

   // Index codes that no register decodes.
   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED_HI = 3'd7;

   typedef struct packed {
      logic [23:0] out_pixel;
      logic [31:0] dst_offset;
      logic [31:0] src_offset;
      logic        last_pixel;
   } blended_pixel_type;

   logic clock = 1'b0;
   logic reset;

   aab_req_if req_ch ();
   aab_rsp_if rsp_ch ();
   aab_csr_if csr_ch ();

   alpha_blend_blit_unit #(
      .MAX_DIM (BLIT_MAX_DIM)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Shadow copy of the configuration and of the raster position.
   logic [11:0] cfg_dest_x;
   logic [11:0] cfg_dest_y;
   logic [12:0] cfg_width;
   logic [12:0] cfg_height;
   logic [15:0] cfg_dest_pitch;
   logic [15:0] cfg_src_pitch;
   logic [11:0] col_pos;
   logic [11:0] row_pos;

   blended_pixel_type pending_pixels[$];

   int error_count   = 0;
   int pixels_sent   = 0;
   int pixels_seen   = 0;
   int blits_done    = 0;
   int reg_writes    = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;

   always #5 clock = ~clock;

   // Receiver: ready is redrawn at every falling edge.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #(RUN_LIMIT);
      $display("Run limit reached with %0d results outstanding.", pending_pixels.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // A size of zero counts as one, and anything above the maximum as the maximum.
   function automatic logic [31:0] effective_dim(input logic [12:0] raw);
      if (raw == 13'd0) begin
         return 32'd1;
      end
      if (raw > 13'(BLIT_MAX_DIM)) begin
         return 32'(BLIT_MAX_DIM);
      end
      return 32'(raw);
   endfunction

   // One colour channel: ((255-a)*dst + a*src)/255, rounded half up.
   function automatic logic [7:0] blend_channel(input logic [7:0] alpha,
                                                input logic [7:0] dst_c,
                                                input logic [7:0] src_c);
      logic [31:0] sum;
      sum = (32'd255 - 32'(alpha)) * 32'(dst_c) + 32'(alpha) * 32'(src_c);
      return 8'((sum + 32'd127) / 32'd255);
   endfunction

   // Works out the response to one pixel pair and advances the raster position.
   function automatic blended_pixel_type blend_and_locate(input logic [31:0] src,
                                                          input logic [31:0] dst);
      blended_pixel_type res;
      logic [31:0]       w;
      logic [31:0]       h;
      logic [31:0]       col;
      logic [31:0]       row;
      logic              row_end;
      logic              col_last;
      w   = effective_dim(cfg_width);
      h   = effective_dim(cfg_height);
      col = 32'(col_pos);
      row = 32'(row_pos);
      res.out_pixel  = {blend_channel(src[31:24], dst[23:16], src[23:16]),
                        blend_channel(src[31:24], dst[15:8], src[15:8]),
                        blend_channel(src[31:24], dst[7:0], src[7:0])};
      res.dst_offset = (32'(cfg_dest_y) + row) * 32'(cfg_dest_pitch)
                     + (32'(cfg_dest_x) + col) * 32'(PIXEL_BYTES);
      res.src_offset = (h - 32'd1 - row) * 32'(cfg_src_pitch) + col * 32'(PIXEL_BYTES);
      row_end  = (col + 32'd1) >= w;
      col_last = (row + 32'd1) >= h;
      res.last_pixel = row_end && col_last;
      // A counter at or past a freshly shrunk size wraps at its next advance.
      if (row_end) begin
         col_pos = 12'd0;
         row_pos = col_last ? 12'd0 : row_pos + 12'd1;
      end else begin
         col_pos = col_pos + 12'd1;
      end
      return res;
   endfunction

   // Mirrors an accepted register write in the shadow configuration.
   function automatic void apply_reg_write(input logic [CSR_INDEX_W-1:0] idx,
                                           input logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_DEST_X:       cfg_dest_x     = value[11:0];
         REG_DEST_Y:       cfg_dest_y     = value[11:0];
         REG_IMAGE_WIDTH:  cfg_width      = value[12:0];
         REG_IMAGE_HEIGHT: cfg_height     = value[12:0];
         REG_DEST_PITCH:   cfg_dest_pitch = value[15:0];
         REG_SRC_PITCH:    cfg_src_pitch  = value[15:0];
         default: ;
      endcase
   endfunction

   // Sends one pixel pair, with random idle cycles ahead of it.
   task automatic send_pixel(input logic [31:0] src, input logic [31:0] dst);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.src_pixel <= src;
      req_ch.dst_pixel <= dst;
      do @(posedge clock); while (!req_ch.ready);
      pending_pixels.push_back(blend_and_locate(src, dst));
      pixels_sent++;
   endtask

   // Stops sending and waits for every outstanding response.
   task automatic wait_for_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_pixels.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // One register write transaction; the block is idle whenever this is called.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      apply_reg_write(idx, value);
      reg_writes++;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Source pixels with fully clear and fully opaque alpha drawn often.
   function automatic logic [31:0] random_source();
      logic [31:0] pix;
      pix = $urandom();
      case ($urandom_range(3))
         0: pix[31:24] = 8'h00;
         1: pix[31:24] = 8'hFF;
         default: ;
      endcase
      return pix;
   endfunction

   // Image sizes: mostly tiny, now and then zero, the maximum or beyond it.
   function automatic logic [CSR_DATA_W-1:0] random_dimension();
      case ($urandom_range(19))
         0:       return '0;
         1:       return CSR_DATA_W'(BLIT_MAX_DIM);
         2:       return CSR_DATA_W'($urandom_range(BLIT_MAX_DIM + 1, 8191));
         3, 4:    return CSR_DATA_W'($urandom_range(9, 64));
         default: return CSR_DATA_W'($urandom_range(1, 8));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_pitch();
      if ($urandom_range(3) == 0) begin
         return CSR_DATA_W'(4 * $urandom_range(1, 64));
      end
      return CSR_DATA_W'($urandom_range(4, 65535));
   endfunction

   // Drains the block and loads a fresh random geometry.
   task automatic randomise_geometry();
      wait_for_results();
      write_reg(REG_DEST_X, CSR_DATA_W'($urandom_range(0, 65535)));
      write_reg(REG_DEST_Y, CSR_DATA_W'($urandom_range(0, 65535)));
      write_reg(REG_IMAGE_WIDTH, random_dimension());
      write_reg(REG_IMAGE_HEIGHT, random_dimension());
      write_reg(REG_DEST_PITCH, random_pitch());
      write_reg(REG_SRC_PITCH, random_pitch());
      if ($urandom_range(7) == 0) begin
         write_reg($urandom_range(1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO,
                   CSR_DATA_W'($urandom()));
      end
   endtask

   // Response checker: each response transaction against the oldest prediction.
   always @(posedge clock) begin
      blended_pixel_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         pixels_seen++;
         if (pending_pixels.size() == 0) begin
            $error("Response with no pixel outstanding: out_pixel %h dst_offset %h",
                   rsp_ch.out_pixel, rsp_ch.dst_offset);
            error_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_ch.out_pixel !== want.out_pixel) begin
               $error("out_pixel: expected %h, got %h", want.out_pixel, rsp_ch.out_pixel);
               error_count++;
            end
            if (rsp_ch.dst_offset !== want.dst_offset) begin
               $error("dst_offset: expected %h, got %h", want.dst_offset, rsp_ch.dst_offset);
               error_count++;
            end
            if (rsp_ch.src_offset !== want.src_offset) begin
               $error("src_offset: expected %h, got %h", want.src_offset, rsp_ch.src_offset);
               error_count++;
            end
            if (rsp_ch.last_pixel !== want.last_pixel) begin
               $error("last_pixel: expected %b, got %b", want.last_pixel, rsp_ch.last_pixel);
               error_count++;
            end
            if (want.last_pixel) begin
               blits_done++;
            end
         end
      end
   end

   // Reset geometry (a single pixel) with the blend extremes.
   task automatic test_default_geometry();
      send_pixel(32'h00FF_FFFF, 32'h0000_0000);
      send_pixel(32'hFF12_3456, 32'hFFAB_CDEF);
      send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
      send_pixel(32'h80FF_FFFF, 32'h0000_0000);
      send_pixel(32'h7F00_0000, 32'hFFFF_FFFF);
      send_pixel(32'h0100_FF00, 32'h00FF_00FF);
      send_pixel(32'hFE80_7F01, 32'h5A7F_80FE);
      wait_for_results();
   endtask

   // Largest values in every register, out-of-range sizes and unmapped indexes.
   task automatic test_register_extremes();
      write_reg(REG_DEST_X, 16'hFFFF);
      write_reg(REG_DEST_Y, 16'h0FFF);
      write_reg(REG_IMAGE_WIDTH, 16'(BLIT_MAX_DIM));
      write_reg(REG_IMAGE_HEIGHT, 16'(BLIT_MAX_DIM));
      write_reg(REG_DEST_PITCH, 16'hFFFF);
      write_reg(REG_SRC_PITCH, 16'hFFFF);
      write_reg(REG_UNMAPPED_LO, 16'hFFFF);
      write_reg(REG_UNMAPPED_HI, 16'h0000);
      repeat (3) send_pixel($urandom(), $urandom());
      wait_for_results();
      // Oversize width is clamped to the maximum; a zero height counts as one.
      write_reg(REG_IMAGE_WIDTH, 16'h1FFF);
      write_reg(REG_IMAGE_HEIGHT, 16'h0000);
      repeat (2) send_pixel($urandom(), $urandom());
      wait_for_results();
      // A zero width ends the blit at once; smallest pitches and origin.
      write_reg(REG_IMAGE_WIDTH, 16'h0000);
      write_reg(REG_DEST_X, 16'h0000);
      write_reg(REG_DEST_Y, 16'h0000);
      write_reg(REG_DEST_PITCH, 16'd4);
      write_reg(REG_SRC_PITCH, 16'd4);
      repeat (2) send_pixel($urandom(), $urandom());
      wait_for_results();
   endtask

   // Shrinking the image part way through a blit forces both counters to wrap,
   // and the source row index runs below zero on the way.
   task automatic test_shrink_mid_blit();
      write_reg(REG_IMAGE_WIDTH, 16'd4);
      write_reg(REG_IMAGE_HEIGHT, 16'd4);
      write_reg(REG_DEST_X, 16'd100);
      write_reg(REG_DEST_Y, 16'd7);
      write_reg(REG_SRC_PITCH, 16'd64);
      repeat (7) send_pixel(random_source(), $urandom());
      wait_for_results();
      write_reg(REG_IMAGE_WIDTH, 16'd2);
      write_reg(REG_IMAGE_HEIGHT, 16'd1);
      repeat (3) send_pixel(random_source(), $urandom());
      wait_for_results();
   endtask

   // Random geometry and pixels under each idle and back-pressure profile.
   task automatic test_random_traffic();
      int send_profile[4];
      int stall_profile[4];
      int until_reconfig;
      send_profile  = '{0, 87, 0, 8};
      stall_profile = '{0, 0, 87, 8};
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = send_profile[p];
         stall_pct      = stall_profile[p];
         until_reconfig = 0;
         for (int n = 0; n < 308; n++) begin
            if (until_reconfig == 0) begin
               randomise_geometry();
               until_reconfig = $urandom_range(20, 60);
            end
            // Hold off mid-stream until the block has emptied completely.
            if (n == 154) begin
               wait_for_results();
            end
            send_pixel(random_source(), $urandom());
            until_reconfig--;
         end
         wait_for_results();
      end
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   // Reset, then the tests in turn.
   initial begin
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.src_pixel  = '0;
      req_ch.dst_pixel  = '0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = REG_DEST_X;
      csr_ch.data       = '0;
      cfg_dest_x        = '0;
      cfg_dest_y        = '0;
      cfg_width         = 13'd1;
      cfg_height        = 13'd1;
      cfg_dest_pitch    = 16'd4;
      cfg_src_pitch     = 16'd4;
      col_pos           = '0;
      row_pos           = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_geometry();
      test_register_extremes();
      test_shrink_mid_blit();
      test_random_traffic();

      wait_for_results();
      repeat (8) @(posedge clock);
      $display("Blended %0d pixel transactions (%0d responses, %0d complete blits)",
               pixels_sent, pixels_seen, blits_done);
      $display("across %0d register writes and four idle/stall profiles.", reg_writes);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
